FILE: hdl/bsa_pkg.sv
package bsa_pkg;

  localparam int DOC_COUNT = 4096;
  localparam int DOC_AW = $clog2(DOC_COUNT);
  localparam int DIV_W = 56;
  localparam int DVS_W = 40;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [1:0] CFG_K1 = 2'd0;
  localparam logic [1:0] CFG_BLEND = 2'd1;
  localparam logic [1:0] CFG_TOTAL = 2'd2;
  localparam logic [1:0] CFG_AVG = 2'd3;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_LOAD  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [11:0] doc_id;
    logic [15:0] term_weight;
    logic [20:0] doc_frequency;
    logic [23:0] doc_length;
    logic        end_of_query;
  } in_word_t;

  typedef struct packed {
    logic [11:0]        doc_id_out;
    logic signed [31:0] score;
    logic               saturated;
    logic               query_done;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage

FILE: hdl/bm25_score_accumulator_top.sv
// bm25 score accumulator
// input channel: in_valid / in_stall with one in_word (op, doc_id, weight,
// doc frequency, doc length, end of query); in_stall is high whenever the
// block is busy with a word. output channel: out_valid / out_stall with one
// out_word per input word, held in a register until taken.
// config channel: cfg_valid / cfg_ready (always ready), cfg_index, cfg_data;
// write only while idle.
// a load writes the length store; a read fetches the score; a clear zeros
// one score entry a cycle; an accumulate runs two logarithms of 24 squarings
// each, one or two 56-step divides and a few products, all through one
// multiplier and one divider, plus up to 30 normalizing shifts per logarithm.
// one word is handled at a time; a word is taken as soon as the
// sequencer is back in idle, even while the last result still waits.
// reset: config returns to its defaults and both stores are zeroed by a
// sweep over all 4096 entries during which in_stall stays high.
// a stalled result holds; a finished word waits in its last state until the
// output register is free.
module bm25_score_accumulator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bsa_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output bsa_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import bsa_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LWR, S_RD, S_RD2, S_LLOAD, S_LNORM, S_LSQ, S_LSQW,
    S_IMUL, S_IW, S_RGO, S_RWT, S_NMUL, S_NW, S_KMUL, S_KW, S_WMUL, S_WW,
    S_TWT, S_CLM, S_CLW, S_CHM, S_CHW, S_RND, S_ACC, S_OUT
  } state_t;

  state_t state;
  in_word_t iw;
  logic [15:0] k1;
  logic [12:0] blend;
  logic [20:0] ntot;
  logic [31:0] avg;

  logic [DOC_AW-1:0] clr_addr;
  logic clr_len;
  logic [23:0] len;
  logic [31:0] score_old;
  logic [31:0] m;
  logic [28:0] r;
  logic [28:0] ln_num;
  logic [4:0] sq_i;
  logic lsel;
  logic neg;
  logic [20:0] idf_mag;
  logic [31:0] ratio;
  logic [31:0] norm;
  logic [35:0] kn;
  logic [36:0] t;
  logic [57:0] pacc;
  logic [41:0] cmag;
  logic [31:0] res_score;
  logic res_sat;

  logic [DOC_AW-1:0] idx;
  logic [DOC_AW-1:0] ram_addr;
  logic score_we, len_we;
  logic [31:0] score_wdata, score_rdata;
  logic [23:0] len_wdata, len_rdata;
  logic [31:0] mul_a, mul_b;
  logic [63:0] p;
  div_req_t dreq;
  logic dbusy;
  logic [DIV_W-1:0] quo;

  logic [12:0] b_eff;
  logic [31:0] avg_eff;
  logic [21:0] num, den;
  logic [28:0] dmag;
  logic [36:0] dsum;
  logic [31:0] sq;
  logic [28:0] r_set;
  logic [43:0] so, sum;
  logic signed [43:0] sum_s;

  assign idx = iw.doc_id[DOC_AW-1:0];
  assign b_eff = (blend > 13'd4096) ? 13'd4096 : blend;
  assign avg_eff = (avg == '0) ? 32'd1 : avg;
  assign num = ({1'b0, iw.doc_frequency} <= {1'b0, ntot}) ?
               22'({1'b0, ntot - iw.doc_frequency} << 1) + 22'd1 : 22'd1;
  assign den = 22'({1'b0, iw.doc_frequency} << 1) + 22'd1;
  assign dmag = (ln_num < r) ? r - ln_num : ln_num - r;
  assign dsum = {5'b0, iw.term_weight, 16'b0} + {1'b0, kn};
  assign sq = p[61:30];
  assign r_set = r | (29'd1 << (5'd23 - sq_i));
  assign so = {{12{score_old[31]}}, score_old};
  assign sum = neg ? so - {2'b0, cmag} : so + {2'b0, cmag};
  assign sum_s = sum;
  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_LSQ: begin
        mul_a = m;
        mul_b = m;
      end
      S_IMUL: begin
        mul_a = {3'b0, dmag};
        mul_b = LN2_Q32;
      end
      S_NMUL: begin
        mul_a = {19'b0, b_eff};
        mul_b = ratio;
      end
      S_KMUL: begin
        mul_a = {16'b0, k1};
        mul_b = norm;
      end
      S_WMUL: begin
        mul_a = {16'b0, iw.term_weight};
        mul_b = {15'b0, 17'(k1) + 17'd4096};
      end
      S_CLM: begin
        mul_a = {11'b0, idf_mag};
        mul_b = t[31:0];
      end
      S_CHM: begin
        mul_a = {11'b0, idf_mag};
        mul_b = {27'b0, t[36:32]};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    dreq.start = (state == S_RGO) || (state == S_WW && dsum != '0);
    dreq.dividend = (state == S_RGO) ? {8'b0, len, 24'b0} : {3'b0, p[32:0], 20'b0};
    dreq.divisor = (state == S_RGO) ? {8'b0, avg_eff} : {3'b0, dsum};
  end

  always_comb begin
    ram_addr = (state == S_CLR) ? clr_addr : idx;
    score_we = (state == S_CLR) || (state == S_OUT && iw.op == OP_ACC);
    score_wdata = (state == S_CLR) ? 32'd0 : res_score;
    len_we = (state == S_CLR && clr_len) || (state == S_LWR);
    len_wdata = (state == S_CLR) ? 24'd0 : iw.doc_length;
  end

  bsa_ram #(.WIDTH(32), .DEPTH(DOC_COUNT)) u_score (
    .clk(clk), .we(score_we), .addr(ram_addr), .wdata(score_wdata),
    .rdata(score_rdata)
  );

  bsa_ram #(.WIDTH(24), .DEPTH(DOC_COUNT)) u_len (
    .clk(clk), .we(len_we), .addr(ram_addr), .wdata(len_wdata),
    .rdata(len_rdata)
  );

  bsa_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  bsa_div u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quotient(quo));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      clr_len <= 1'b1;
      out_valid <= 1'b0;
      k1 <= 16'd4915;
      blend <= 13'd3072;
      ntot <= 21'd4096;
      avg <= 32'd256;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_K1: k1 <= cfg_data[15:0];
          CFG_BLEND: blend <= cfg_data[12:0];
          CFG_TOTAL: ntot <= cfg_data[20:0];
          CFG_AVG: avg <= cfg_data;
          default: begin
          end
        endcase
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == DOC_AW'(DOC_COUNT - 1)) begin
            clr_len <= 1'b0;
            state <= clr_len ? S_IDLE : S_OUT;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            iw <= in_word;
            res_score <= '0;
            res_sat <= 1'b0;
            unique case (in_word.op)
              OP_LOAD: state <= S_LWR;
              OP_CLEAR: begin
                clr_addr <= '0;
                state <= S_CLR;
              end
              default: state <= S_RD;
            endcase
          end
        end
        S_LWR: state <= S_OUT;
        S_RD: state <= S_RD2;
        S_RD2: begin
          len <= len_rdata;
          score_old <= score_rdata;
          lsel <= 1'b0;
          if (iw.op == OP_READ) begin
            res_score <= score_rdata;
            state <= S_OUT;
          end else begin
            state <= S_LLOAD;
          end
        end
        S_LLOAD: begin
          m <= 32'(lsel ? den : num);
          r <= 29'(30) << 24;
          state <= S_LNORM;
        end
        S_LNORM: begin
          if (m[30]) begin
            sq_i <= '0;
            state <= S_LSQ;
          end else begin
            m <= m << 1;
            r <= r - (29'd1 << 24);
          end
        end
        S_LSQ: state <= S_LSQW;
        S_LSQW: begin
          m <= sq[31] ? {1'b0, sq[31:1]} : sq;
          if (sq[31]) begin
            r <= r_set;
          end
          sq_i <= sq_i + 5'd1;
          if (sq_i == 5'd23) begin
            if (!lsel) begin
              ln_num <= sq[31] ? r_set : r;
              lsel <= 1'b1;
              state <= S_LLOAD;
            end else begin
              state <= S_IMUL;
            end
          end else begin
            state <= S_LSQ;
          end
        end
        S_IMUL: begin
          neg <= ln_num < r;
          state <= S_IW;
        end
        S_IW: begin
          idf_mag <= 21'((p + (64'd1 << 39)) >> 40);
          state <= S_RGO;
        end
        S_RGO: state <= S_RWT;
        S_RWT: begin
          if (!dbusy) begin
            ratio <= (quo > DIV_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : quo[31:0];
            state <= S_NMUL;
          end
        end
        S_NMUL: state <= S_NW;
        S_NW: begin
          norm <= 32'((p + (64'(13'd4096 - b_eff) << 16)) >> 12);
          state <= S_KMUL;
        end
        S_KMUL: state <= S_KW;
        S_KW: begin
          kn <= p[47:12];
          state <= S_WMUL;
        end
        S_WMUL: state <= S_WW;
        S_WW: begin
          if (dsum == '0) begin
            t <= '0;
            state <= S_CLM;
          end else begin
            state <= S_TWT;
          end
        end
        S_TWT: begin
          if (!dbusy) begin
            t <= quo[36:0];
            state <= S_CLM;
          end
        end
        S_CLM: state <= S_CLW;
        S_CLW: begin
          pacc <= p[57:0];
          state <= S_CHM;
        end
        S_CHM: state <= S_CHW;
        S_CHW: begin
          pacc <= pacc + {p[25:0], 32'b0};
          state <= S_RND;
        end
        S_RND: begin
          cmag <= 42'((pacc + 58'd32768) >> 16);
          state <= S_ACC;
        end
        S_ACC: begin
          if (sum_s > 44'sd2147483647) begin
            res_score <= 32'h7FFF_FFFF;
            res_sat <= 1'b1;
          end else if (sum_s < -44'sd2147483648) begin
            res_score <= 32'h8000_0000;
            res_sat <= 1'b1;
          end else begin
            res_score <= sum[31:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_word.doc_id_out <= iw.doc_id;
            out_word.score <= res_score;
            out_word.saturated <= res_sat;
            out_word.query_done <= iw.end_of_query;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/bsa_ram.sv
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/bsa_mul.sv
module bsa_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

FILE: hdl/bsa_div.sv
module bsa_div (
  input  logic                    clk,
  input  logic                    rst,
  input  bsa_pkg::div_req_t       req,
  output logic                    busy,
  output logic [bsa_pkg::DIV_W-1:0] quotient
);
  import bsa_pkg::*;

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [5:0]       cnt;
  logic [DVS_W:0]   trial;
  logic             ge;

  assign trial = {rem, quotient[DIV_W-1]};
  assign ge = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 6'(DIV_W);
      quotient <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
      quotient <= {quotient[DIV_W-2:0], ge};
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: verif/bm25_score_accumulator_top_tb.sv
module bm25_score_accumulator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsa_pkg::*;

  localparam longint unsigned LN2_FRAC = 64'd2977044472;
  localparam int IDLE_LIMIT = 50000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_K1;
  logic [31:0] cfg_data = '0;

  bm25_score_accumulator_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [15:0] k1_q;
  logic [12:0] blend_q;
  logic [20:0] total_q;
  logic [31:0] avg_q;
  logic [31:0] scores [DOC_COUNT];
  logic [23:0] lengths [DOC_COUNT];

  in_word_t pending_words [$];
  out_word_t expected_results [$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;

  function automatic longint unsigned log2_fixed(longint unsigned x);
    int e;
    longint unsigned m, r;
    e = 0;
    if (x == 0) x = 1;
    while (e < 30 && (x >> (e + 1)) != 0) e++;
    m = x << (30 - e);
    r = longint'(e) << 24;
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        r |= 64'd1 << (23 - i);
      end
    end
    return r;
  endfunction

  function automatic out_word_t score_word(in_word_t w);
    out_word_t o;
    longint unsigned n, df, num, den, ln_n, ln_d, dmag, idf_mag, avg, b, k;
    longint unsigned ratio, norm, kn, dd, t, cmag, tw;
    logic [127:0] wide;
    longint s;
    bit neg;
    o = '0;
    o.doc_id_out = w.doc_id;
    o.query_done = w.end_of_query;
    case (w.op)
      OP_ACC: begin
        n = total_q;
        df = w.doc_frequency;
        tw = w.term_weight;
        num = (df <= n) ? 2 * (n - df) + 1 : 1;
        den = 2 * df + 1;
        ln_n = log2_fixed(num);
        ln_d = log2_fixed(den);
        neg = ln_n < ln_d;
        dmag = neg ? ln_d - ln_n : ln_n - ln_d;
        wide = 128'(dmag) * 128'(LN2_FRAC) + (128'd1 << 39);
        idf_mag = 64'(wide >> 40);
        avg = avg_q ? avg_q : 1;
        b = blend_q > 4096 ? 4096 : blend_q;
        k = k1_q;
        ratio = (longint'(lengths[w.doc_id]) << 24) / avg;
        if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
        norm = ((4096 - b) * 65536 + b * ratio) / 4096;
        kn = (k * norm) / 4096;
        dd = (tw << 16) + kn;
        t = dd ? ((tw * (k + 4096) * 16) << 16) / dd : 0;
        wide = 128'(idf_mag) * 128'(t) + (128'd1 << 15);
        cmag = 64'(wide >> 16);
        s = longint'($signed(scores[w.doc_id])) + (neg ? -longint'(cmag) : longint'(cmag));
        if (s > 64'sd2147483647) begin
          s = 64'sd2147483647;
          o.saturated = 1'b1;
        end
        if (s < -64'sd2147483648) begin
          s = -64'sd2147483648;
          o.saturated = 1'b1;
        end
        scores[w.doc_id] = s[31:0];
        o.score = s[31:0];
      end
      OP_LOAD: lengths[w.doc_id] = w.doc_length;
      OP_READ: o.score = scores[w.doc_id];
      default: foreach (scores[i]) scores[i] = '0;
    endcase
    return o;
  endfunction

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(score_word(in_word));
        void'(pending_words.pop_front());
      end
      if (in_valid && in_stall) begin
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_words.size() > 0 && !(in_valid && !in_stall &&
                   pending_words.size() == 0)) begin
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_word <= pending_words[0];
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern plus long hold-offs
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 1999) == 0) begin
      hold_off <= $urandom_range(1500, 3000);
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 7) < 3);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation, doc_id_out %0d", out_word.doc_id_out);
          errors = errors + 1;
        end else begin
          out_word_t e;
          e = expected_results.pop_front();
          if (out_word.doc_id_out !== e.doc_id_out) begin
            $error("doc_id_out expected %0d actual %0d", e.doc_id_out, out_word.doc_id_out);
            errors = errors + 1;
          end
          if (out_word.score !== e.score) begin
            $error("score expected %0d actual %0d", e.score, out_word.score);
            errors = errors + 1;
          end
          if (out_word.saturated !== e.saturated) begin
            $error("saturated expected %0b actual %0b", e.saturated, out_word.saturated);
            errors = errors + 1;
          end
          if (out_word.query_done !== e.query_done) begin
            $error("query_done expected %0b actual %0b", e.query_done, out_word.query_done);
            errors = errors + 1;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic in_word_t make_word(op_t op, int id, int w, int df, int len, bit eoq);
    in_word_t x;
    x.op = op;
    x.doc_id = 12'(id);
    x.term_weight = 16'(w);
    x.doc_frequency = 21'(df);
    x.doc_length = 24'(len);
    x.end_of_query = eoq;
    return x;
  endfunction

  function automatic in_word_t random_word();
    in_word_t x;
    int sel;
    x = '0;
    x.doc_id = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                           : 12'($urandom_range(0, 15));
    x.term_weight = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 20));
    sel = $urandom_range(0, 5);
    x.doc_frequency = (sel == 0) ? 21'($urandom_range(0, 21'h1FFFFF)) :
                      (sel == 1) ? 21'($urandom_range(0, 1048576)) :
                                   21'($urandom_range(0, 5000));
    x.doc_length = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 24'hFFFFFF))
                                                : 24'($urandom_range(0, 1000));
    x.end_of_query = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    x.op = sel < 65 ? OP_ACC : sel < 85 ? OP_LOAD : sel < 99 ? OP_READ : OP_CLEAR;
    return x;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_K1: k1_q = value[15:0];
      CFG_BLEND: blend_q = value[12:0];
      CFG_TOTAL: total_q = value[20:0];
      default: avg_q = value;
    endcase
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic run_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        int id;
        id = $urandom_range(0, 15);
        pending_words.push_back(make_word(OP_LOAD, id, 0, 0, $urandom_range(0, 2000), 0));
        for (int j = 0; j < 4; j++)
          pending_words.push_back(make_word(OP_ACC, id, $urandom_range(1, 30),
                                            $urandom_range(0, 4096), 0, j == 3));
        pending_words.push_back(make_word(OP_READ, id, 0, 0, 0, 1));
        i += 5;
      end else begin
        pending_words.push_back(random_word());
      end
    end
    drain();
  endtask

  initial begin
    k1_q = 16'd4915;
    blend_q = 13'd3072;
    total_q = 21'd4096;
    avg_q = 32'd256;
    foreach (scores[i]) begin
      scores[i] = '0;
      lengths[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // directed
    pending_words.push_back(make_word(OP_READ, 4095, 0, 0, 0, 1));
    pending_words.push_back(make_word(OP_LOAD, 4095, 65535, 0, 24'hFFFFFF, 0));
    pending_words.push_back(make_word(OP_ACC, 4095, 65535, 0, 0, 0));
    pending_words.push_back(make_word(OP_ACC, 4095, 0, 0, 0, 1));
    pending_words.push_back(make_word(OP_ACC, 0, 1, 4096, 0, 0));
    pending_words.push_back(make_word(OP_ACC, 0, 1, 21'h1FFFFF, 0, 0));
    pending_words.push_back(make_word(OP_ACC, 0, 5, 1048576, 0, 1));
    pending_words.push_back(make_word(OP_ACC, 1, 65535, 0, 0, 0));
    for (int i = 0; i < 6; i++)
      pending_words.push_back(make_word(OP_ACC, 2, 65535, 0, 0, 0));
    pending_words.push_back(make_word(OP_READ, 2, 0, 0, 0, 0));
    pending_words.push_back(make_word(OP_CLEAR, 5, 0, 0, 0, 1));
    pending_words.push_back(make_word(OP_READ, 4095, 0, 0, 0, 0));
    drain();
    // zero document total, zero avg, blend above one, k1 zero
    write_reg(CFG_K1, 32'd0);
    write_reg(CFG_BLEND, 32'd8191);
    write_reg(CFG_TOTAL, 32'd0);
    write_reg(CFG_AVG, 32'd0);
    pending_words.push_back(make_word(OP_ACC, 3, 0, 0, 0, 0));
    pending_words.push_back(make_word(OP_ACC, 3, 4, 7, 0, 1));
    pending_words.push_back(make_word(OP_LOAD, 3, 0, 0, 24'hFFFFFF, 0));
    pending_words.push_back(make_word(OP_ACC, 3, 4, 0, 0, 1));
    drain();
    write_reg(CFG_K1, 32'hFFFF_FFFF);
    write_reg(CFG_BLEND, 32'd0);
    write_reg(CFG_TOTAL, 32'h001F_FFFF);
    write_reg(CFG_AVG, 32'hFFFF_FFFF);
    run_phase(300);
    write_reg(CFG_K1, 32'd4915);
    write_reg(CFG_BLEND, 32'd4096);
    write_reg(CFG_TOTAL, 32'd1048576);
    write_reg(CFG_AVG, 32'd1);
    run_phase(300);
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_K1, $urandom_range(0, 65535));
      write_reg(CFG_BLEND, $urandom_range(0, 8191));
      write_reg(CFG_TOTAL, $urandom_range(0, 2 * 1048576 - 1));
      write_reg(CFG_AVG, $urandom());
      run_phase(300);
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

FILE: bm25_score_accumulator_top.f
hdl/bsa_pkg.sv
hdl/bsa_ram.sv
hdl/bsa_mul.sv
hdl/bsa_div.sv
hdl/bm25_score_accumulator_top.sv
verif/bm25_score_accumulator_top_tb.sv
